### hw/rtl/hsvha_pkg.sv
// Shared types and constants of the HSV hue and saturation adjuster.
`timescale 1ns / 1ps
`default_nettype none
package hsvha_pkg;

  localparam int unsigned HueSixth = 3840;
  localparam int unsigned HueFull  = 23040;
  localparam int unsigned SatOne   = 65536;
  localparam int unsigned RcpShift = 24;
  localparam int unsigned Div15Mul = 286331153;

  localparam logic [1:0] CFG_ADJUST_MODE = 2'd0;
  localparam logic [1:0] CFG_SAT_GAIN    = 2'd1;
  localparam logic [1:0] CFG_HUE_SHIFT   = 2'd2;

  localparam logic [15:0] SAT_GAIN_RESET = 16'd4096;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pix_out_t;

  typedef struct packed {
    logic [7:0]  mx;
    logic [16:0] sat;
    logic [14:0] hue;
  } hsv_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] gain;
    logic [9:0]  shift;
  } cfg_t;

endpackage
`default_nettype wire

### hw/rtl/hsvha_conv.sv
// RGB to HSV conversion pipeline: prepare, reciprocal multiply, correct.
`timescale 1ns / 1ps
`default_nettype none
module hsvha_conv import hsvha_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    vld_i,
  output logic         rdy_o,
  input  wire pix_in_t pix_i,
  output logic         vld_o,
  input  wire logic    rdy_i,
  output hsv_t         hsv_o
);

  logic [24:0] rcp_tbl [256];

  for (genvar i = 0; i < 256; i++) begin : g_rcp
    localparam int unsigned Den = (i == 0) ? 1 : i;
    localparam int unsigned Val = (i == 0) ? 0 : ((1 << RcpShift) / Den);
    assign rcp_tbl[i] = 25'(Val);
  end

  // prepare
  logic [7:0]  r, g, b, mx_nxt, mn, dl_nxt;
  logic [8:0]  diff;
  logic        neg_nxt;
  logic [7:0]  absd;
  logic [14:0] base_nxt;
  logic [19:0] numh_nxt;

  always_comb begin
    r = pix_i.red_in;
    g = pix_i.green_in;
    b = pix_i.blue_in;
    mx_nxt = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
    mn     = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
    dl_nxt = mx_nxt - mn;
    priority if (mx_nxt == r) begin
      diff     = {1'b0, g} - {1'b0, b};
      base_nxt = 15'd0;
    end else if (mx_nxt == g) begin
      diff     = {1'b0, b} - {1'b0, r};
      base_nxt = 15'(2 * HueSixth);
    end else begin
      diff     = {1'b0, r} - {1'b0, g};
      base_nxt = 15'(4 * HueSixth);
    end
    neg_nxt  = diff[8];
    absd     = neg_nxt ? 8'(-diff) : diff[7:0];
    numh_nxt = 20'(absd * 12'(HueSixth));
  end

  logic        c1_v_r, c2_v_r, c3_v_r;
  logic        c1_en, c2_en, c3_en;
  logic [7:0]  c1_mx_r, c1_dl_r, c2_mx_r, c2_dl_r;
  logic [24:0] c1_rcs_r, c1_rch_r;
  logic [19:0] c1_numh_r, c2_numh_r;
  logic        c1_neg_r, c2_neg_r;
  logic [14:0] c1_base_r, c2_base_r;
  logic [16:0] c2_qs_r;
  logic [12:0] c2_qh_r;

  assign c3_en = !c3_v_r || rdy_i;
  assign c2_en = !c2_v_r || c3_en;
  assign c1_en = !c1_v_r || c2_en;
  assign rdy_o = c1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0;
      c2_v_r <= 1'b0;
      c3_v_r <= 1'b0;
    end else begin
      if (c1_en) c1_v_r <= vld_i;
      if (c2_en) c2_v_r <= c1_v_r;
      if (c3_en) c3_v_r <= c2_v_r;
    end
  end

  // reciprocal multiply
  logic [48:0] prod_s;
  logic [44:0] prod_h;
  logic [16:0] qs_nxt;
  logic [12:0] qh_nxt;

  always_comb begin
    prod_s = {c1_dl_r, 16'b0} * c1_rcs_r;
    prod_h = c1_numh_r * c1_rch_r;
    qs_nxt = prod_s[40:24];
    qh_nxt = prod_h[36:24];
  end

  // correct and form hue and saturation
  logic [24:0] rs;
  logic [20:0] rh, rhc;
  logic [16:0] sat_q;
  logic [12:0] qh;
  logic [13:0] qhr;
  logic signed [16:0] hue_s;
  hsv_t        hsv_nxt;

  always_comb begin
    rs    = {1'b0, c2_dl_r, 16'b0} - 25'(c2_qs_r * c2_mx_r);
    sat_q = (rs >= 25'(c2_mx_r)) ? c2_qs_r + 17'd1 : c2_qs_r;
    rh    = {1'b0, c2_numh_r} - 21'(c2_qh_r * c2_dl_r);
    qh    = (rh >= 21'(c2_dl_r)) ? c2_qh_r + 13'd1 : c2_qh_r;
    rhc   = (rh >= 21'(c2_dl_r)) ? rh - 21'(c2_dl_r) : rh;
    qhr   = {1'b0, qh} + {13'd0, (rhc != 21'd0)};
    hue_s = c2_neg_r ? $signed({2'b0, c2_base_r}) - $signed({3'b0, qhr})
                     : $signed({2'b0, c2_base_r}) + $signed({4'b0, qh});
    if (hue_s < 0) hue_s = hue_s + 17'sd23040;
    hsv_nxt.mx = c2_mx_r;
    if (c2_dl_r == 8'd0) begin
      hsv_nxt.sat = 17'd0;
      hsv_nxt.hue = 15'd0;
    end else begin
      hsv_nxt.sat = sat_q;
      hsv_nxt.hue = hue_s[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (c1_en) begin
      c1_mx_r   <= mx_nxt;
      c1_dl_r   <= dl_nxt;
      c1_rcs_r  <= rcp_tbl[mx_nxt];
      c1_rch_r  <= rcp_tbl[dl_nxt];
      c1_numh_r <= numh_nxt;
      c1_neg_r  <= neg_nxt;
      c1_base_r <= base_nxt;
    end
    if (c2_en) begin
      c2_mx_r   <= c1_mx_r;
      c2_dl_r   <= c1_dl_r;
      c2_numh_r <= c1_numh_r;
      c2_neg_r  <= c1_neg_r;
      c2_base_r <= c1_base_r;
      c2_qs_r   <= qs_nxt;
      c2_qh_r   <= qh_nxt;
    end
    if (c3_en) hsv_o <= hsv_nxt;
  end

  assign vld_o = c3_v_r;

endmodule
`default_nettype wire

### hw/rtl/hsvha_adj.sv
// Saturation gain or hue rotation stage.
`timescale 1ns / 1ps
`default_nettype none
module hsvha_adj import hsvha_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg_i,
  input  wire logic vld_i,
  output logic      rdy_o,
  input  wire hsv_t hsv_i,
  output logic      vld_o,
  input  wire logic rdy_i,
  output hsv_t      hsv_o
);

  logic        v_r, en;
  logic [32:0] prod;
  logic [20:0] scaled;
  logic [17:0] rot;
  logic [16:0] rotu;
  hsv_t        hsv_nxt;

  assign en    = !v_r || rdy_i;
  assign rdy_o = en;
  assign vld_o = v_r;

  always_comb begin
    hsv_nxt = hsv_i;
    prod    = hsv_i.sat * cfg_i.gain;
    scaled  = prod[32:12];
    rot     = {3'b0, hsv_i.hue} + {{2{cfg_i.shift[9]}}, cfg_i.shift, 6'b0} + 18'd46080;
    rotu    = rot[16:0];
    if (!cfg_i.mode) begin
      hsv_nxt.sat = (scaled > 21'(SatOne)) ? 17'(SatOne) : scaled[16:0];
    end else begin
      priority if (rotu >= 17'(4 * HueFull)) hsv_nxt.hue = 15'(rotu - 17'(4 * HueFull));
      else if (rotu >= 17'(3 * HueFull)) hsv_nxt.hue = 15'(rotu - 17'(3 * HueFull));
      else if (rotu >= 17'(2 * HueFull)) hsv_nxt.hue = 15'(rotu - 17'(2 * HueFull));
      else if (rotu >= 17'(HueFull)) hsv_nxt.hue = 15'(rotu - 17'(HueFull));
      else hsv_nxt.hue = rotu[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (en) v_r <= vld_i;
  end

  always_ff @(posedge clk) begin
    if (en) hsv_o <= hsv_nxt;
  end

endmodule
`default_nettype wire

### hw/rtl/hsvha_back.sv
// HSV to RGB conversion pipeline with output register.
`timescale 1ns / 1ps
`default_nettype none
module hsvha_back import hsvha_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic vld_i,
  output logic      rdy_o,
  input  wire hsv_t hsv_i,
  output logic      vld_o,
  input  wire logic rdy_i,
  output pix_out_t  pix_o
);

  typedef enum logic [2:0] {
    SEC_RY, SEC_YG, SEC_GC, SEC_CB, SEC_BM, SEC_MR
  } sec_t;

  logic b1_v_r, b2_v_r, b3_v_r, b4_v_r;
  logic b1_en, b2_en, b3_en, b4_en;

  assign b4_en = !b4_v_r || rdy_i;
  assign b3_en = !b3_v_r || b4_en;
  assign b2_en = !b2_v_r || b3_en;
  assign b1_en = !b1_v_r || b2_en;
  assign rdy_o = b1_en;
  assign vld_o = b4_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
      b4_v_r <= 1'b0;
    end else begin
      if (b1_en) b1_v_r <= vld_i;
      if (b2_en) b2_v_r <= b1_v_r;
      if (b3_en) b3_v_r <= b2_v_r;
      if (b4_en) b4_v_r <= b3_v_r;
    end
  end

  // chroma, sector and ramp weight
  logic [23:0] cf_nxt;
  sec_t        sec_nxt;
  logic [14:0] t;
  logic [11:0] hdist, f_nxt;

  always_comb begin
    cf_nxt = 24'(hsv_i.mx * hsv_i.sat);
    priority if (hsv_i.hue >= 15'(5 * HueSixth)) sec_nxt = SEC_MR;
    else if (hsv_i.hue >= 15'(4 * HueSixth)) sec_nxt = SEC_BM;
    else if (hsv_i.hue >= 15'(3 * HueSixth)) sec_nxt = SEC_CB;
    else if (hsv_i.hue >= 15'(2 * HueSixth)) sec_nxt = SEC_GC;
    else if (hsv_i.hue >= 15'(HueSixth)) sec_nxt = SEC_YG;
    else sec_nxt = SEC_RY;
    unique case (sec_nxt)
      SEC_RY, SEC_YG: t = hsv_i.hue;
      SEC_GC, SEC_CB: t = hsv_i.hue - 15'(2 * HueSixth);
      default:        t = hsv_i.hue - 15'(4 * HueSixth);
    endcase
    hdist = (t >= 15'(HueSixth)) ? 12'(t - 15'(HueSixth)) : 12'(15'(HueSixth) - t);
    f_nxt = 12'(HueSixth) - hdist;
  end

  logic [7:0]  b1_mx_r;
  logic [23:0] b1_cf_r, b2_cf_r, b3_cf_r;
  logic [11:0] b1_f_r;
  sec_t        b1_sec_r, b2_sec_r, b3_sec_r;
  logic [27:0] b2_v_nxt, b2_val_r, b3_val_r;
  logic [23:0] b2_mf_nxt, b2_mf_r, b3_mf_r;
  logic [35:0] ramp;
  logic [56:0] pm;
  logic [24:0] b3_q_r;

  always_comb begin
    ramp      = b1_cf_r * b1_f_r;
    b2_v_nxt  = ramp[35:8];
    b2_mf_nxt = {b1_mx_r, 16'b0} - b1_cf_r;
    pm        = b2_val_r * 29'(Div15Mul);
  end

  // finish divide by fifteen and pick channels
  logic [27:0] rr;
  logic [23:0] xf;
  logic [23:0] ch0, ch1, ch2;
  logic [24:0] s0, s1, s2;
  pix_out_t    pix_nxt;

  always_comb begin
    rr = b3_val_r - 28'({b3_q_r, 4'b0} - {4'b0, b3_q_r});
    xf = (rr >= 28'd15) ? 24'(b3_q_r + 25'd1) : b3_q_r[23:0];
    unique case (b3_sec_r)
      SEC_RY:  begin ch0 = b3_cf_r; ch1 = xf;      ch2 = 24'd0;   end
      SEC_YG:  begin ch0 = xf;      ch1 = b3_cf_r; ch2 = 24'd0;   end
      SEC_GC:  begin ch0 = 24'd0;   ch1 = b3_cf_r; ch2 = xf;      end
      SEC_CB:  begin ch0 = 24'd0;   ch1 = xf;      ch2 = b3_cf_r; end
      SEC_BM:  begin ch0 = xf;      ch1 = 24'd0;   ch2 = b3_cf_r; end
      default: begin ch0 = b3_cf_r; ch1 = 24'd0;   ch2 = xf;      end
    endcase
    s0 = {1'b0, ch0} + {1'b0, b3_mf_r};
    s1 = {1'b0, ch1} + {1'b0, b3_mf_r};
    s2 = {1'b0, ch2} + {1'b0, b3_mf_r};
    pix_nxt.red_out   = s0[23:16];
    pix_nxt.green_out = s1[23:16];
    pix_nxt.blue_out  = s2[23:16];
  end

  always_ff @(posedge clk) begin
    if (b1_en) begin
      b1_mx_r  <= hsv_i.mx;
      b1_cf_r  <= cf_nxt;
      b1_f_r   <= f_nxt;
      b1_sec_r <= sec_nxt;
    end
    if (b2_en) begin
      b2_val_r <= b2_v_nxt;
      b2_mf_r  <= b2_mf_nxt;
      b2_cf_r  <= b1_cf_r;
      b2_sec_r <= b1_sec_r;
    end
    if (b3_en) begin
      b3_q_r   <= pm[56:32];
      b3_val_r <= b2_val_r;
      b3_mf_r  <= b2_mf_r;
      b3_cf_r  <= b2_cf_r;
      b3_sec_r <= b2_sec_r;
    end
    if (b4_en) pix_o <= pix_nxt;
  end

endmodule
`default_nettype wire

### hw/rtl/hsv_hue_saturation_adjust.sv
// Top level of the HSV hue and saturation adjuster.
// Takes one RGB pixel per clock and returns one adjusted pixel per clock while
// out_stall is low. The eight register stages are three for RGB to HSV (the
// two divides run as reciprocal-table multiplies with one correction step),
// one for the saturation gain or hue rotation, and four for HSV to RGB (two
// multiplies, then the divide by 3840 done as a shift and a reciprocal
// multiply). Each stage holds its item while the one after it is full and
// stalled, so the pipeline fills bubbles; in_stall rises only when every stage
// is full and out_stall is high. Configuration writes take effect on the items
// in the adjust stage at the next clock.
`timescale 1ns / 1ps
`default_nettype none
module hsv_hue_saturation_adjust import hsvha_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire pix_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output pix_out_t         out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [15:0] cfg_wdata
);

  cfg_t cfg_r;
  logic conv_vld, conv_rdy, adj_vld, adj_rdy, back_rdy;
  hsv_t conv_hsv, adj_hsv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= 1'b0;
      cfg_r.gain  <= SAT_GAIN_RESET;
      cfg_r.shift <= 10'd0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ADJUST_MODE: cfg_r.mode  <= cfg_wdata[0];
        CFG_SAT_GAIN:    cfg_r.gain  <= cfg_wdata;
        CFG_HUE_SHIFT:   cfg_r.shift <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  hsvha_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (in_valid),
    .rdy_o (conv_rdy),
    .pix_i (in_data),
    .vld_o (conv_vld),
    .rdy_i (adj_rdy),
    .hsv_o (conv_hsv)
  );

  hsvha_adj u_adj (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_i (cfg_r),
    .vld_i (conv_vld),
    .rdy_o (adj_rdy),
    .hsv_i (conv_hsv),
    .vld_o (adj_vld),
    .rdy_i (back_rdy),
    .hsv_o (adj_hsv)
  );

  hsvha_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (adj_vld),
    .rdy_o (back_rdy),
    .hsv_i (adj_hsv),
    .vld_o (out_valid),
    .rdy_i (!out_stall),
    .pix_o (out_data)
  );

  assign in_stall = !conv_rdy;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && adj_vld && conv_vld))
    else $error("input stalled while pipeline has room");

  a_conv_range: assert property (@(posedge clk) disable iff (!rst_n)
    conv_vld |-> (conv_hsv.hue < 15'(HueFull) && conv_hsv.sat <= 17'(SatOne)
                  && (conv_hsv.mx != 8'd0 || conv_hsv.sat == 17'd0)))
    else $error("converted HSV out of range");

  a_adj_range: assert property (@(posedge clk) disable iff (!rst_n)
    adj_vld |-> (adj_hsv.hue < 15'(HueFull) && adj_hsv.sat <= 17'(SatOne)))
    else $error("adjusted HSV out of range");

endmodule
`default_nettype wire
